>>> src/hakmc_pkg.sv
// shared constants, codes and state type for the hunt-and-kill maze carver
package hakmc_pkg;

  localparam int GRID_W   = 63;
  localparam int GRID_H   = 63;
  localparam int WALKERS  = 16;
  localparam int CW       = 6;
  localparam int WIDX     = 4;
  localparam int ROW_AW   = 6;
  localparam int ROWS     = 1 << ROW_AW;
  localparam int COLS_ODD = (GRID_W - 1) / 2;
  localparam int COL_AW   = 5;
  localparam int CNT_W    = 5;

  localparam logic [1:0] ACT_SEED = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] OC_SEEDED  = 3'd0;
  localparam logic [2:0] OC_CARVED  = 3'd1;
  localparam logic [2:0] OC_HUNTED  = 3'd2;
  localparam logic [2:0] OC_RETIRED = 3'd3;
  localparam logic [2:0] OC_IGNORED = 3'd4;
  localparam logic [2:0] OC_READ    = 3'd5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SEEDW, S_READ, S_DIR, S_DCHK, S_CMID, S_HLOAD, S_HNEXT
  } state_t;

endpackage

>>> src/hunt_and_kill_maze_carver_unit.sv
// hunt-and-kill maze carver: grid row memory, walker table and step sequencer
//
// input channel in_*: one beat per item; in_tuser holds the action, in_tdata
// the walker, cell and shuffle fields. every item gives exactly one result
// beat on out_*; out_tuser holds the outcome.
// the grid sits in a row-wide memory (one row per word) that a single
// read port and a single write port serve; a small sequencer drives both.
// ignored items finish in the idle state; a seed reads its row and writes
// it back, a read reads the row; a step tries directions in shuffled order,
// reading the target row of each one in bounds, and a carve writes that row,
// with one extra read/write for a vertical carve. hunt or retire: the
// direction checks, one load state and one scan per odd row (up to 31),
// each odd row checked against its neighbor rows, one row per cycle.
// one item is in work at a time; in_tready is low until its result is
// loaded into the output register.
// reset: a clearing pass writes wall to all 64 rows, with in_tready low;
// the active flags and the active count are cleared at once.
// a stalled receiver holds the result in the output register; a new item
// is taken once the register is empty or being emptied in the same cycle.
module hunt_and_kill_maze_carver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [23:0] in_tdata,   // walker, cell_x, cell_y, shuffle_draws
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // outcome
  output logic [39:0] out_tdata   // walker_out, pos_x, pos_y, passage_x, passage_y,
                                  // cell_value, active_walkers, zero fill
);

  typedef logic [hakmc_pkg::GRID_W-1:0] row_t;
  typedef logic [hakmc_pkg::CW-1:0]     crd_t;

  hakmc_pkg::state_t state_r, state_nxt;

  row_t mem [hakmc_pkg::ROWS];
  row_t rdata_r;
  logic [hakmc_pkg::ROW_AW-1:0] raddr, waddr, clr_r;
  logic wen;
  row_t wdata;

  crd_t wx_r [hakmc_pkg::WALKERS];
  crd_t wy_r [hakmc_pkg::WALKERS];
  logic [hakmc_pkg::WALKERS-1:0] wact_r;
  logic [hakmc_pkg::CNT_W-1:0]   cnt_r;

  logic [hakmc_pkg::WIDX-1:0] w_r;
  crd_t cx_r, cy_r, x_r, y_r, hr_r;
  logic [7:0] draws_r;
  logic [1:0] di_r;
  row_t above_r, cur_r;

  logic out_valid_r;
  logic [2:0] oc_r;
  logic [hakmc_pkg::WIDX-1:0] ow_r;
  crd_t opx_r, opy_r, oqx_r, oqy_r;
  logic oval_r;
  logic [hakmc_pkg::CNT_W-1:0] ocnt_r;

  logic [1:0] in_act;
  logic [hakmc_pkg::WIDX-1:0] in_w;
  crd_t in_cx, in_cy;
  logic in_acc, seed_ok;

  logic fin, wupd, act_set, act_clr;
  logic [2:0] f_oc;
  logic [hakmc_pkg::WIDX-1:0] f_w;
  crd_t f_px, f_py, f_qx, f_qy, upd_x, upd_y;
  logic f_val;
  logic [hakmc_pkg::CNT_W-1:0] f_cnt;

  logic [1:0] order [4];
  logic [1:0] dcur;
  logic d_ok, d_horiz;
  crd_t tx, ty, mx, my;

  logic [hakmc_pkg::COLS_ODD-1:0] cand;
  logic found;
  logic [hakmc_pkg::COL_AW-1:0] fk;

  function automatic row_t bit_of(input crd_t idx);
    bit_of = row_t'(1) << idx;
  endfunction

  assign in_act = in_tuser;
  assign in_w   = in_tdata[3:0];
  assign in_cx  = in_tdata[9:4];
  assign in_cy  = in_tdata[15:10];
  assign in_tready = (state_r == hakmc_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc = in_tvalid && in_tready;

  assign seed_ok = (32'(in_w) < hakmc_pkg::WALKERS) && in_cx[0] && in_cy[0]
                   && (32'(in_cx) + 2 <= hakmc_pkg::GRID_W)
                   && (32'(in_cy) + 2 <= hakmc_pkg::GRID_H);

  // direction order from the four swap draws
  always_comb begin
    logic [1:0] t;
    logic [1:0] j;
    order[0] = hakmc_pkg::DIR_UP;
    order[1] = hakmc_pkg::DIR_DOWN;
    order[2] = hakmc_pkg::DIR_LEFT;
    order[3] = hakmc_pkg::DIR_RIGHT;
    for (int i = 0; i < 4; i++) begin
      j = draws_r[2*i +: 2];
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  end

  assign dcur = order[di_r];

  always_comb begin
    d_ok = 1'b0;
    d_horiz = 1'b0;
    tx = x_r;
    ty = y_r;
    mx = x_r;
    my = y_r;
    case (dcur)
      hakmc_pkg::DIR_UP: begin
        d_ok = (y_r > crd_t'(2));
        ty = y_r - crd_t'(2);
        my = y_r - crd_t'(1);
      end
      hakmc_pkg::DIR_DOWN: begin
        d_ok = (y_r <= crd_t'(hakmc_pkg::GRID_H - 4));
        ty = y_r + crd_t'(2);
        my = y_r + crd_t'(1);
      end
      hakmc_pkg::DIR_LEFT: begin
        d_ok = (x_r > crd_t'(2));
        d_horiz = 1'b1;
        tx = x_r - crd_t'(2);
        mx = x_r - crd_t'(1);
      end
      default: begin
        d_ok = (x_r <= crd_t'(hakmc_pkg::GRID_W - 4));
        d_horiz = 1'b1;
        tx = x_r + crd_t'(2);
        mx = x_r + crd_t'(1);
      end
    endcase
  end

  // hunt check of one odd row: rows above, current and below (rdata_r)
  always_comb begin
    for (int k = 0; k < hakmc_pkg::COLS_ODD; k++) begin
      cand[k] = cur_r[2*k+1] &
        ((hr_r != crd_t'(1) && !above_r[2*k+1]) ||
         (hr_r != crd_t'(hakmc_pkg::GRID_H - 2) && !rdata_r[2*k+1]) ||
         (k != 0 && !cur_r[(2*k+hakmc_pkg::GRID_W-1) % hakmc_pkg::GRID_W]) ||
         (k != hakmc_pkg::COLS_ODD - 1 && !cur_r[(2*k+3) % hakmc_pkg::GRID_W]));
    end
    found = 1'b0;
    fk = '0;
    for (int k = hakmc_pkg::COLS_ODD - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        fk = hakmc_pkg::COL_AW'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    wen = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    fin = 1'b0;
    wupd = 1'b0;
    act_set = 1'b0;
    act_clr = 1'b0;
    upd_x = x_r;
    upd_y = y_r;
    f_oc = hakmc_pkg::OC_IGNORED;
    f_w = w_r;
    f_px = x_r;
    f_py = y_r;
    f_qx = '0;
    f_qy = '0;
    f_val = 1'b0;
    case (state_r)
      hakmc_pkg::S_CLR: begin
        wen = 1'b1;
        waddr = clr_r;
        if (clr_r == hakmc_pkg::ROW_AW'(hakmc_pkg::ROWS - 1)) begin
          state_nxt = hakmc_pkg::S_IDLE;
        end
      end
      hakmc_pkg::S_IDLE: begin
        f_w = in_w;
        f_px = wx_r[in_w];
        f_py = wy_r[in_w];
        raddr = in_cy;
        if (in_acc) begin
          case (in_act)
            hakmc_pkg::ACT_SEED: begin
              if (seed_ok) state_nxt = hakmc_pkg::S_SEEDW;
              else fin = 1'b1;
            end
            hakmc_pkg::ACT_STEP: begin
              if (wact_r[in_w]) state_nxt = hakmc_pkg::S_DIR;
              else fin = 1'b1;
            end
            hakmc_pkg::ACT_READ: state_nxt = hakmc_pkg::S_READ;
            default: fin = 1'b1;
          endcase
        end
      end
      hakmc_pkg::S_SEEDW: begin
        wen = 1'b1;
        waddr = cy_r;
        wdata = rdata_r | bit_of(cx_r);
        wupd = 1'b1;
        upd_x = cx_r;
        upd_y = cy_r;
        act_set = 1'b1;
        fin = 1'b1;
        f_oc = hakmc_pkg::OC_SEEDED;
        f_px = cx_r;
        f_py = cy_r;
      end
      hakmc_pkg::S_READ: begin
        fin = 1'b1;
        f_oc = hakmc_pkg::OC_READ;
        f_w = '0;
        f_px = '0;
        f_py = '0;
        if (32'(cx_r) < hakmc_pkg::GRID_W && 32'(cy_r) < hakmc_pkg::GRID_H) begin
          f_val = rdata_r[cx_r];
        end
      end
      hakmc_pkg::S_DIR: begin
        if (d_ok) begin
          raddr = ty;
          state_nxt = hakmc_pkg::S_DCHK;
        end else if (di_r == 2'd3) begin
          raddr = crd_t'(1);
          state_nxt = hakmc_pkg::S_HLOAD;
        end
      end
      hakmc_pkg::S_DCHK: begin
        if (!rdata_r[tx]) begin
          wen = 1'b1;
          waddr = ty;
          if (d_horiz) begin
            wdata = rdata_r | bit_of(tx) | bit_of(mx);
            wupd = 1'b1;
            upd_x = tx;
            upd_y = ty;
            fin = 1'b1;
            f_oc = hakmc_pkg::OC_CARVED;
            f_px = tx;
            f_py = ty;
            f_qx = mx;
            f_qy = my;
          end else begin
            wdata = rdata_r | bit_of(tx);
            raddr = my;
            state_nxt = hakmc_pkg::S_CMID;
          end
        end else if (di_r == 2'd3) begin
          raddr = crd_t'(1);
          state_nxt = hakmc_pkg::S_HLOAD;
        end else begin
          state_nxt = hakmc_pkg::S_DIR;
        end
      end
      hakmc_pkg::S_CMID: begin
        wen = 1'b1;
        waddr = my;
        wdata = rdata_r | bit_of(mx);
        wupd = 1'b1;
        upd_x = tx;
        upd_y = ty;
        fin = 1'b1;
        f_oc = hakmc_pkg::OC_CARVED;
        f_px = tx;
        f_py = ty;
        f_qx = mx;
        f_qy = my;
      end
      hakmc_pkg::S_HLOAD: begin
        raddr = hr_r + crd_t'(2);
        state_nxt = hakmc_pkg::S_HNEXT;
      end
      hakmc_pkg::S_HNEXT: begin
        if (found) begin
          wupd = 1'b1;
          upd_x = {fk, 1'b1};
          upd_y = hr_r;
          fin = 1'b1;
          f_oc = hakmc_pkg::OC_HUNTED;
          f_px = {fk, 1'b1};
          f_py = hr_r;
        end else if (hr_r == crd_t'(hakmc_pkg::GRID_H - 2)) begin
          act_clr = 1'b1;
          fin = 1'b1;
          f_oc = hakmc_pkg::OC_RETIRED;
        end else begin
          raddr = hr_r + crd_t'(4);
        end
      end
      default: state_nxt = hakmc_pkg::S_IDLE;
    endcase
    if (fin) state_nxt = hakmc_pkg::S_IDLE;
    f_cnt = cnt_r;
    if (act_set && !wact_r[w_r]) f_cnt = cnt_r + hakmc_pkg::CNT_W'(1);
    if (act_clr) f_cnt = cnt_r - hakmc_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hakmc_pkg::S_CLR;
      clr_r <= '0;
      wact_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hakmc_pkg::S_CLR) clr_r <= clr_r + hakmc_pkg::ROW_AW'(1);
      if (act_set) wact_r[w_r] <= 1'b1;
      if (act_clr) wact_r[w_r] <= 1'b0;
      cnt_r <= f_cnt;
      if (fin) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      w_r <= in_w;
      cx_r <= in_cx;
      cy_r <= in_cy;
      draws_r <= in_tdata[23:16];
      x_r <= wx_r[in_w];
      y_r <= wy_r[in_w];
      di_r <= '0;
    end
    if ((state_r == hakmc_pkg::S_DIR && !d_ok) ||
        (state_r == hakmc_pkg::S_DCHK && rdata_r[tx])) begin
      di_r <= di_r + 2'd1;
    end
    if (state_r == hakmc_pkg::S_HLOAD) cur_r <= rdata_r;
    if (state_nxt == hakmc_pkg::S_HLOAD) hr_r <= crd_t'(1);
    if (state_r == hakmc_pkg::S_HNEXT) begin
      above_r <= cur_r;
      cur_r <= rdata_r;
      hr_r <= hr_r + crd_t'(2);
    end
    if (wupd) begin
      wx_r[w_r] <= upd_x;
      wy_r[w_r] <= upd_y;
    end
    if (fin) begin
      oc_r <= f_oc;
      ow_r <= f_w;
      opx_r <= f_px;
      opy_r <= f_py;
      oqx_r <= f_qx;
      oqy_r <= f_qy;
      oval_r <= f_val;
      ocnt_r <= f_cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = oc_r;
  assign out_tdata = {6'd0, ocnt_r, oval_r, oqy_r, oqx_r, opy_r, opx_r, ow_r};

endmodule
